/* rtl/oaht_pkg.sv */
// oaht_pkg: shared types, opcodes, status codes and a hash helper for the open-addressing hash table.
// No dependencies.
`default_nettype none
package oaht_pkg;
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, start probe at first slot
    logic rd;        // issue read of current slot
    logic advance;   // step probe hash to next slot
    logic wr_value;  // write value at current slot
    logic wr_insert; // write key, hash, value and set valid
    logic clr_valid; // clear valid at current slot
    logic cnt_inc;
    logic cnt_dec;
  } oaht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_empty;
    logic slot_match;
    logic last_probe;
    logic has_room;
    logic hash_zero;
    logic [1:0] op;
  } oaht_sts_t;

  function automatic logic [31:0] mangle(input logic [31:0] h);
    mangle = ((h >> 7) ^ (h << 9)) + h;
  endfunction
endpackage
`default_nettype wire

/* rtl/open_addressing_hash_table.sv */
// open_addressing_hash_table: top level, joins controller, datapath and result register.
// Depends on oaht_pkg, oaht_ctrl, oaht_datapath.
// Each request is accepted, then each probed slot takes a memory read step
// and then a compare-and-act step; the result beat is registered and held
// until taken, and the next request is accepted only once it is gone, so a
// new request is never taken before the last one is through. Lookup
// and remove with a zero hash miss; a set that would add an entry while
// entry_count >= size-2 answers status 2. Valid bits sit in flip-flops and are
// cleared by synchronous reset; key, hash and value memories are not cleared.
// table_size_log2 below 3 acts as 3, above log2(SLOTS) as SLOTS.
`default_nettype none
module open_addressing_hash_table #(
  parameter int SLOTS      = 256,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_table_size_log2,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [63:0] in_key,
  input  wire logic [31:0] in_key_hash,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [63:0]      out_value_out,
  output logic [1:0]       out_status,
  output logic [8:0]       out_entry_count
);
  import oaht_pkg::*;

  logic [3:0] size_log2_r;
  oaht_cmd_t cmd;
  oaht_sts_t sts;
  logic [VALUE_BITS-1:0] rd_value;
  logic [8:0] count;
  logic res_load, res_found, res_take_value;
  logic [1:0] res_status;
  logic [8:0] count_after;

  always_ff @(posedge clk) begin
    if (!rst_n) size_log2_r <= 4'd8;
    else if (cfg_we) size_log2_r <= cfg_table_size_log2;
  end

  oaht_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd,
    .res_load, .res_found, .res_take_value, .res_status);

  oaht_datapath #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .size_log2(size_log2_r), .in_operation, .in_key, .in_key_hash,
    .in_value, .cmd, .sts, .rd_value, .count);

  // count as it will stand after this beat's update
  always_comb begin
    count_after = count;
    if (cmd.cnt_inc) count_after = count + 9'd1;
    else if (cmd.cnt_dec && count != 9'd0) count_after = count - 9'd1;
  end

  // result register holds the beat until taken
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_found       <= res_found;
      out_value_out   <= res_take_value ? 64'(rd_value) : 64'd0;
      out_status      <= res_status;
      out_entry_count <= count_after;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_entry_count)) else $error("result changed");
  a_full_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_status == ST_FULL) |-> !cmd.cnt_inc) else $error("full but inserted");
  a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
    res_take_value |-> res_found) else $error("value on miss");
endmodule
`default_nettype wire

/* rtl/oaht_ram.sv */
// oaht_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/oaht_datapath.sv */
// oaht_datapath: request registers, probe hash, slot memories, valid bits, count.
// Depends on oaht_pkg and oaht_ram.
`default_nettype none
module oaht_datapath #(
  parameter int SLOTS      = 256,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [3:0]           size_log2,
  input  wire logic [1:0]           in_operation,
  input  wire logic [63:0]          in_key,
  input  wire logic [31:0]          in_key_hash,
  input  wire logic [63:0]          in_value,
  input  wire oaht_pkg::oaht_cmd_t  cmd,
  output oaht_pkg::oaht_sts_t       sts,
  output logic [VALUE_BITS-1:0]     rd_value,
  output logic [8:0]                count
);
  import oaht_pkg::*;
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [1:0]            op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [31:0]           hash_r, h_r, h_nxt;
  logic [VALUE_BITS-1:0] val_r;
  logic [AW-1:0]         mask_r, slot;
  logic [AW:0]           size_r, n_r;
  logic [CW-1:0]         cnt_r;
  logic [SLOTS-1:0]      valid_r;
  logic                  valid_q;
  logic [KEY_BITS-1:0]   rd_key;
  logic [31:0]           rd_hash;
  logic [AW:0]           size_c;
  logic [3:0]            lg;

  // effective size: clamp log to [3, log2(SLOTS)]
  always_comb begin
    lg = (size_log2 < 4'd3) ? 4'd3 : size_log2;
    if (32'(lg) >= AW) size_c = (AW+1)'(SLOTS);
    else size_c = (AW+1)'(1) << lg;
  end

  assign slot  = h_r[AW-1:0] & mask_r;
  assign h_nxt = cmd.load ? in_key_hash : mangle(h_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      key_r  <= in_key[KEY_BITS-1:0];
      hash_r <= in_key_hash;
      val_r  <= in_value[VALUE_BITS-1:0];
      size_r <= size_c;
      mask_r <= AW'(size_c - 1'b1);
      n_r    <= '0;
    end else if (cmd.advance) begin
      n_r <= n_r + 1'b1;
    end
    if (cmd.load || cmd.advance) h_r <= h_nxt;
    if (cmd.rd) valid_q <= valid_r[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cmd.wr_insert) valid_r[slot] <= 1'b1;
      if (cmd.clr_valid) valid_r[slot] <= 1'b0;
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      else if (cmd.cnt_dec && cnt_r != '0) cnt_r <= cnt_r - 1'b1;
    end
  end

  oaht_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
    .clk, .we(cmd.wr_insert), .waddr(slot), .wdata(key_r), .raddr(slot), .rdata(rd_key));
  oaht_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_hash (
    .clk, .we(cmd.wr_insert), .waddr(slot), .wdata(hash_r), .raddr(slot), .rdata(rd_hash));
  oaht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val (
    .clk, .we(cmd.wr_insert | cmd.wr_value), .waddr(slot), .wdata(val_r),
    .raddr(slot), .rdata(rd_value));

  always_comb begin
    sts.slot_empty = !valid_q;
    sts.slot_match = valid_q && rd_hash == hash_r && rd_key == key_r;
    sts.last_probe = (n_r + 1'b1) >= size_r;
    sts.has_room   = ((CW+1)'(cnt_r) + (CW+1)'(2)) < (CW+1)'(size_r);
    sts.hash_zero  = hash_r == '0;
    sts.op         = op_r;
  end
  assign count = 9'(cnt_r);
endmodule
`default_nettype wire

/* rtl/oaht_ctrl.sv */
// oaht_ctrl: request sequencer for probe, update and result beat.
// Depends on oaht_pkg.
`default_nettype none
module oaht_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire oaht_pkg::oaht_sts_t sts,
  output oaht_pkg::oaht_cmd_t      cmd,
  output logic                     res_load,
  output logic                     res_found,
  output logic                     res_take_value,
  output logic [1:0]               res_status
);
  import oaht_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0, S_READ = 2'd1, S_EVAL = 2'd2;
  logic [1:0] state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic done;

  assign in_ready  = state_r == S_IDLE && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    done = 1'b0;
    res_found = 1'b0;
    res_take_value = 1'b0;
    res_status = ST_NOTFOUND;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        priority if (sts.op == OP_LOOKUP || sts.op == OP_REMOVE) begin
          if (sts.hash_zero || sts.slot_empty) begin
            done = 1'b1;
          end else if (sts.slot_match) begin
            done = 1'b1;
            res_found = 1'b1;
            res_status = ST_OK;
            if (sts.op == OP_LOOKUP) res_take_value = 1'b1;
            else begin
              cmd.clr_valid = 1'b1;
              cmd.cnt_dec = 1'b1;
            end
          end else if (sts.last_probe) begin
            done = 1'b1;
          end else cmd.advance = 1'b1;
        end else if (sts.op == OP_SET) begin
          if (sts.slot_match) begin
            done = 1'b1;
            res_found = 1'b1;
            res_status = ST_OK;
            cmd.wr_value = 1'b1;
          end else if (sts.slot_empty) begin
            done = 1'b1;
            if (sts.has_room) begin
              res_status = ST_OK;
              cmd.wr_insert = 1'b1;
              cmd.cnt_inc = 1'b1;
            end else res_status = ST_FULL;
          end else if (sts.last_probe) begin
            done = 1'b1;
            res_status = ST_FULL;
          end else cmd.advance = 1'b1;
        end else begin
          done = 1'b1;
        end
        state_nxt = done ? S_IDLE : S_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = done ? 1'b1 : (out_valid_r && !out_ready);
  end
  assign res_load = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_insert && cmd.clr_valid)) else $error("insert and clear together");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid) else $error("result beat lost");
  a_read_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_EVAL)) else $error("read not evaluated");
endmodule
`default_nettype wire
